[sv/rdsgd_pkg.sv]
// Shared types, constants and the AF code decoder for the RDS group decoder.
// Used by rdsgd_text_store, rdsgd_group_proc and rds_group_decoder_core.
// No dependencies.
package rdsgd_pkg;

  // Item kinds carried on the input tuser bit.
  localparam logic CMD_GROUP = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Group type numbers that the decoder acts on.
  localparam logic [3:0] GT_BASIC = 4'd0;
  localparam logic [3:0] GT_TEXT  = 4'd2;

  localparam int NAME_LEN  = 8;
  localparam int TEXT_LEN  = 64;
  localparam int TEXT_ROWS = TEXT_LEN / 4;
  localparam int ROW_W     = $clog2(TEXT_ROWS);

  localparam logic [7:0] NAME_FILL = 8'h2E;
  localparam logic [7:0] TEXT_FILL = 8'h20;

  // AF code ranges and frequency bases.
  localparam logic [7:0]  AF_VHF_SET_LO = 8'd225;
  localparam logic [7:0]  AF_VHF_SET_HI = 8'd249;
  localparam logic [7:0]  AF_LFMF_SET   = 8'd250;
  localparam logic [7:0]  AF_VHF_MAX    = 8'd204;
  localparam logic [10:0] AF_VHF_BASE   = 11'd875;
  localparam logic [16:0] AF_VHF_STEP   = 17'd100;
  localparam logic [7:0]  AF_LF_MAX     = 8'd15;
  localparam logic [7:0]  AF_MF_LO      = 8'd16;
  localparam logic [7:0]  AF_MF_MAX     = 8'd135;
  localparam logic [16:0] AF_LF_BASE    = 17'd153;
  localparam logic [16:0] AF_MF_BASE    = 17'd531;
  localparam logic [16:0] AF_LFMF_STEP  = 17'd9;

  typedef struct packed {
    logic       cmd;
    logic [6:0] read_index;
    logic [15:0] block_d;
    logic [15:0] block_c;
    logic [15:0] block_b;
    logic [15:0] block_a;
  } item_t;

  // Declared high field first so that the packed vector matches tdata order.
  typedef struct packed {
    logic [7:0]  read_char;
    logic        text_ab;
    logic [16:0] af_second_khz;
    logic [16:0] af_first_khz;
    logic [6:0]  flag_bits;
    logic [4:0]  prog_type;
    logic [15:0] prog_id;
    logic        is_version_b;
    logic [3:0]  grp_num;
  } result_t;

  typedef struct packed {
    logic             clear;
    logic             en;
    logic [ROW_W-1:0] row;
    logic [3:0]       be;
    logic [31:0]      data;
  } text_wr_t;

  typedef struct packed {
    logic [16:0] khz;
    logic        band_lfmf;
  } af_out_t;

  // Decodes one AF code against the current band and returns the band after it.
  function automatic af_out_t af_decode(input logic [7:0] code, input logic band_lfmf);
    af_out_t     r;
    logic [10:0] sum;
    logic [7:0]  d;
    r.khz       = '0;
    r.band_lfmf = band_lfmf;
    sum         = {3'b0, code} + AF_VHF_BASE;
    d           = '0;
    if (code >= AF_VHF_SET_LO && code <= AF_VHF_SET_HI) begin
      r.band_lfmf = 1'b0;
    end else if (code == AF_LFMF_SET) begin
      r.band_lfmf = 1'b1;
    end else if (!band_lfmf) begin
      if (code >= 8'd1 && code <= AF_VHF_MAX) begin
        r.khz = 17'(sum) * AF_VHF_STEP;
      end
    end else if (code >= 8'd1 && code <= AF_LF_MAX) begin
      d     = code - 8'd1;
      r.khz = AF_LF_BASE + 17'(d) * AF_LFMF_STEP;
    end else if (code >= AF_MF_LO && code <= AF_MF_MAX) begin
      d     = code - AF_MF_LO;
      r.khz = AF_MF_BASE + 17'(d) * AF_LFMF_STEP;
    end
    return r;
  endfunction

endpackage

[sv/rdsgd_text_store.sv]
// Radiotext store: rows of four characters with one valid bit per row.
// An invalid row reads as spaces, so a text clear only drops the valid bits.
// Depends on rdsgd_pkg.
module rdsgd_text_store (
  input  logic                     clk,
  input  logic                     rst,
  input  rdsgd_pkg::text_wr_t      wr,
  input  logic [rdsgd_pkg::ROW_W-1:0] rd_row,
  output logic [31:0]              rd_word
);

  logic [31:0]                     rows [rdsgd_pkg::TEXT_ROWS];
  logic [rdsgd_pkg::TEXT_ROWS-1:0] valid;
  logic [rdsgd_pkg::TEXT_ROWS-1:0] valid_next;
  logic [31:0]                     merged;
  logic                            old_ok;

  // Bytes that are not written keep the old row, or become spaces when the
  // row is empty or is being cleared in this beat.
  always_comb begin
    old_ok = valid[wr.row] && !wr.clear;
    for (int i = 0; i < 4; i++) begin
      if (wr.be[i]) begin
        merged[8*i +: 8] = wr.data[8*i +: 8];
      end else if (old_ok) begin
        merged[8*i +: 8] = rows[wr.row][8*i +: 8];
      end else begin
        merged[8*i +: 8] = rdsgd_pkg::TEXT_FILL;
      end
    end
  end

  always_comb begin
    valid_next = wr.clear ? '0 : valid;
    if (wr.en) begin
      valid_next[wr.row] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      rows[wr.row] <= merged;
    end
  end

  assign rd_word = valid[rd_row] ? rows[rd_row] : {4{rdsgd_pkg::TEXT_FILL}};

endmodule

[sv/rdsgd_group_proc.sv]
// Group processing: PI, PTY, flags, band, A/B flag and service name state,
// AF decoding, text write and character read for one item per beat.
// Depends on rdsgd_pkg; drives rdsgd_text_store.
module rdsgd_group_proc (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  rdsgd_pkg::item_t            item,
  input  logic [31:0]                 rd_word,
  output logic [rdsgd_pkg::ROW_W-1:0] rd_row,
  output rdsgd_pkg::text_wr_t         wr,
  output rdsgd_pkg::result_t          result
);

  logic [15:0] pi_code;
  logic [4:0]  pty_code;
  logic [6:0]  status_flags;
  logic        band_lfmf;
  logic        ab_flag;
  logic [7:0]  service_name [rdsgd_pkg::NAME_LEN];

  logic [6:0]  status_next;
  logic        band_next;
  logic        ab_next;
  logic        is_group;
  logic        is_basic;
  logic        is_text;
  logic [3:0]  gtype;
  logic        verb;
  logic [1:0]  name_seg;
  logic [3:0]  text_seg;
  logic [6:0]  text_pos;
  logic [4:0]  row_a;
  logic [4:0]  row_b;
  rdsgd_pkg::af_out_t af1;
  rdsgd_pkg::af_out_t af2;

  assign gtype    = item.block_b[15:12];
  assign verb     = item.block_b[11];
  assign is_group = (item.cmd == rdsgd_pkg::CMD_GROUP);
  assign is_basic = is_group && (gtype == rdsgd_pkg::GT_BASIC);
  assign is_text  = is_group && (gtype == rdsgd_pkg::GT_TEXT);
  assign name_seg = item.block_b[1:0];
  assign text_seg = item.block_b[3:0];
  assign text_pos = item.read_index - 7'd8;
  assign rd_row   = text_pos[rdsgd_pkg::ROW_W+1:2];
  assign row_a    = {1'b0, text_seg};
  assign row_b    = {2'b0, text_seg[3:1]};

  // The first AF code may change the band used for the second one.
  assign af1 = rdsgd_pkg::af_decode(item.block_c[15:8], band_lfmf);
  assign af2 = rdsgd_pkg::af_decode(item.block_c[7:0], af1.band_lfmf);

  always_comb begin
    status_next = {status_flags[6:3], item.block_b[3], item.block_b[4], item.block_b[10]};
    for (int i = 0; i < 4; i++) begin
      if (name_seg == 2'(i)) begin
        status_next[3+i] = item.block_b[2];
      end
    end
    band_next = (is_basic && !verb) ? af2.band_lfmf : band_lfmf;
    ab_next   = is_text ? item.block_b[4] : ab_flag;
  end

  // Text write: a full row in version A, half a row in version B.
  always_comb begin
    wr.clear = fire && is_text && (item.block_b[4] != ab_flag);
    if (!verb) begin
      wr.en   = fire && is_text && (row_a < 5'(rdsgd_pkg::TEXT_ROWS));
      wr.row  = row_a[rdsgd_pkg::ROW_W-1:0];
      wr.be   = 4'b1111;
      wr.data = {item.block_d[7:0], item.block_d[15:8],
                 item.block_c[7:0], item.block_c[15:8]};
    end else begin
      wr.en   = fire && is_text && (row_b < 5'(rdsgd_pkg::TEXT_ROWS));
      wr.row  = row_b[rdsgd_pkg::ROW_W-1:0];
      wr.be   = text_seg[0] ? 4'b1100 : 4'b0011;
      wr.data = {2{item.block_d[7:0], item.block_d[15:8]}};
    end
  end

  always_comb begin
    result               = '0;
    result.text_ab       = is_group ? ab_next : ab_flag;
    result.prog_id       = is_group ? item.block_a : pi_code;
    result.prog_type     = is_group ? item.block_b[9:5] : pty_code;
    result.flag_bits     = is_basic ? status_next : status_flags;
    if (is_group) begin
      result.grp_num      = gtype;
      result.is_version_b = verb;
      if (is_basic && !verb) begin
        result.af_first_khz  = af1.khz;
        result.af_second_khz = af2.khz;
      end
    end else if (item.read_index < 7'(rdsgd_pkg::NAME_LEN)) begin
      result.read_char = service_name[item.read_index[2:0]];
    end else if (text_pos < 7'(rdsgd_pkg::TEXT_LEN)) begin
      result.read_char = rd_word[{text_pos[1:0], 3'b000} +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pi_code      <= '0;
      pty_code     <= '0;
      status_flags <= '0;
      band_lfmf    <= 1'b0;
      ab_flag      <= 1'b0;
      for (int i = 0; i < rdsgd_pkg::NAME_LEN; i++) begin
        service_name[i] <= rdsgd_pkg::NAME_FILL;
      end
    end else if (fire && is_group) begin
      pi_code   <= item.block_a;
      pty_code  <= item.block_b[9:5];
      band_lfmf <= band_next;
      ab_flag   <= ab_next;
      if (is_basic) begin
        status_flags                   <= status_next;
        service_name[{name_seg, 1'b0}] <= item.block_d[15:8];
        service_name[{name_seg, 1'b1}] <= item.block_d[7:0];
      end
    end
  end

endmodule

[sv/rds_group_decoder_core.sv]
// Top level of the RDS group decoder: input register, group processing and
// text store, output register.
// Depends on rdsgd_pkg, rdsgd_text_store and rdsgd_group_proc.
//
//  channel  | beat                         | tdata / tuser
//  ---------+------------------------------+--------------------------------
//  s_*      | one RDS group or read request| tdata 72 bits, tuser = cmd
//  m_*      | one result per input beat    | tdata 80 bits, no tuser
//
// An input beat is registered, then processed combinationally into the output
// register, and one beat is taken every cycle while the output does not stall.
// Reset clears all state: the name reads as dots and the text as spaces.
// A text clear on an A/B change takes effect in the same beat.
// When m_tready is low the output register holds and the input register
// keeps one more beat before s_tready drops.
module rds_group_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // block_a[15:0], block_b[31:16], block_c[47:32], block_d[63:48],
  // read_index[70:64], zero [71]
  input  logic [71:0] s_tdata,
  // cmd[0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // grp_num[3:0], is_version_b[4], prog_id[20:5], prog_type[25:21],
  // flag_bits[32:26], af_first_khz[49:33], af_second_khz[66:50], text_ab[67],
  // read_char[75:68], zero [79:76]
  output logic [79:0] m_tdata
);

  logic                        in_valid;
  rdsgd_pkg::item_t            in_item;
  logic                        adv;
  logic                        fire;
  rdsgd_pkg::result_t          result;
  rdsgd_pkg::result_t          out_res;
  rdsgd_pkg::text_wr_t         wr;
  logic [rdsgd_pkg::ROW_W-1:0] rd_row;
  logic [31:0]                 rd_word;

  assign adv      = !m_tvalid || m_tready;
  assign fire     = in_valid && adv;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.cmd        <= s_tuser[0];
      in_item.block_a    <= s_tdata[15:0];
      in_item.block_b    <= s_tdata[31:16];
      in_item.block_c    <= s_tdata[47:32];
      in_item.block_d    <= s_tdata[63:48];
      in_item.read_index <= s_tdata[70:64];
    end
  end

  rdsgd_group_proc u_proc (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .item    (in_item),
    .rd_word (rd_word),
    .rd_row  (rd_row),
    .wr      (wr),
    .result  (result)
  );

  rdsgd_text_store u_text (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_row  (rd_row),
    .rd_word (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= result;
    end
  end

  assign m_tdata = {4'b0000, out_res};

  // Every beat that leaves the input register lands in the output register.
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("processed beat did not produce a result");

  // A stalled input beat is neither lost nor changed.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !adv |=> in_valid && $stable(in_item))
    else $error("input register changed while stalled");

  // Frequencies only come from 0A groups.
  a_af_only_0a: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[49:33] != 17'd0 || m_tdata[66:50] != 17'd0) |->
      m_tdata[3:0] == rdsgd_pkg::GT_BASIC && !m_tdata[4])
    else $error("AF frequency on a result that is not 0A");

  // A character only comes back on reads, which report group type zero.
  a_char_only_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[75:68] != 8'd0 |->
      m_tdata[3:0] == rdsgd_pkg::GT_BASIC && !m_tdata[4] &&
      m_tdata[49:33] == 17'd0)
    else $error("character returned on a group result");

endmodule

[tb/sv/tb_rds_group_decoder_core.sv]
// Self-checking testbench for rds_group_decoder_core: directed RDS groups and reads,
// then random traffic with random stalls on both streams, checked against a predictor.
// Depends on rdsgd_pkg and rds_group_decoder_core.
module tb_rds_group_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD  = 300;
  localparam int PHASES     = 14;
  localparam int PHASE_LEN  = 100;
  localparam int SETTLE     = 20;

  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_LIGHT} idle_mode_t;

  // Tracks the decoder's stored state and queues the result each beat should produce.
  class rds_result_checker;
    rdsgd_pkg::result_t expected_q[$];
    bit [15:0]   pi;
    bit [4:0]    pty;
    bit [6:0]    flags;
    bit          lfmf;
    bit          ab;
    bit [7:0]    name_chars[rdsgd_pkg::NAME_LEN];
    bit [7:0]    text_chars[rdsgd_pkg::TEXT_LEN];
    int          n_errors;
    int          n_checked;

    function new();
      pi    = '0;
      pty   = '0;
      flags = '0;
      lfmf  = 1'b0;
      ab    = 1'b0;
      foreach (name_chars[i]) name_chars[i] = rdsgd_pkg::NAME_FILL;
      foreach (text_chars[i]) text_chars[i] = rdsgd_pkg::TEXT_FILL;
      n_errors  = 0;
      n_checked = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Band-switch codes return zero and change the sticky band for later codes.
    function bit [16:0] af_khz(bit [7:0] code);
      int c;
      c = code;
      if (code >= rdsgd_pkg::AF_VHF_SET_LO && code <= rdsgd_pkg::AF_VHF_SET_HI) begin
        lfmf = 1'b0;
        return '0;
      end
      if (code == rdsgd_pkg::AF_LFMF_SET) begin
        lfmf = 1'b1;
        return '0;
      end
      if (!lfmf) return (c >= 1 && c <= 204) ? 17'(100 * (c + 875)) : 17'd0;
      if (c >= 1 && c <= 15) return 17'(153 + 9 * (c - 1));
      if (c >= 16 && c <= 135) return 17'(531 + 9 * (c - 16));
      return '0;
    endfunction

    function void put_char(int pos, bit [7:0] ch);
      if (pos < rdsgd_pkg::TEXT_LEN) text_chars[pos] = ch;
    endfunction

    function void note_beat(rdsgd_pkg::item_t it);
      rdsgd_pkg::result_t r;
      int      seg;
      int      idx;
      r = '0;
      if (it.cmd == rdsgd_pkg::CMD_READ) begin
        idx = it.read_index;
        if (idx < rdsgd_pkg::NAME_LEN) begin
          r.read_char = name_chars[idx];
        end else if (idx - rdsgd_pkg::NAME_LEN < rdsgd_pkg::TEXT_LEN) begin
          r.read_char = text_chars[idx - rdsgd_pkg::NAME_LEN];
        end
      end else begin
        r.grp_num      = it.block_b[15:12];
        r.is_version_b = it.block_b[11];
        pi  = it.block_a;
        pty = it.block_b[9:5];
        if (it.block_b[15:12] == rdsgd_pkg::GT_BASIC) begin
          seg = it.block_b[1:0];
          flags[0] = it.block_b[10];
          flags[1] = it.block_b[4];
          flags[2] = it.block_b[3];
          flags[3 + seg] = it.block_b[2];
          name_chars[seg * 2]     = it.block_d[15:8];
          name_chars[seg * 2 + 1] = it.block_d[7:0];
          if (!it.block_b[11]) begin
            r.af_first_khz  = af_khz(it.block_c[15:8]);
            r.af_second_khz = af_khz(it.block_c[7:0]);
          end
        end else if (it.block_b[15:12] == rdsgd_pkg::GT_TEXT) begin
          seg = it.block_b[3:0];
          if (it.block_b[4] != ab) begin
            foreach (text_chars[i]) text_chars[i] = rdsgd_pkg::TEXT_FILL;
            ab = it.block_b[4];
          end
          if (!it.block_b[11]) begin
            put_char(seg * 4,     it.block_c[15:8]);
            put_char(seg * 4 + 1, it.block_c[7:0]);
            put_char(seg * 4 + 2, it.block_d[15:8]);
            put_char(seg * 4 + 3, it.block_d[7:0]);
          end else begin
            put_char(seg * 2,     it.block_d[15:8]);
            put_char(seg * 2 + 1, it.block_d[7:0]);
          end
        end
      end
      r.prog_id   = pi;
      r.prog_type = pty;
      r.flag_bits = flags;
      r.text_ab   = ab;
      expected_q.push_back(r);
    endfunction

    function void check_beat(rdsgd_pkg::result_t got);
      rdsgd_pkg::result_t exp_r;
      string   diffs;
      n_checked++;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result beat %0d: %p", n_checked, got);
        return;
      end
      exp_r = expected_q.pop_front();
      diffs = "";
      if (got.grp_num !== exp_r.grp_num)
        diffs = {diffs, $sformatf(" grp_num %0d/%0d", exp_r.grp_num, got.grp_num)};
      if (got.is_version_b !== exp_r.is_version_b)
        diffs = {diffs, $sformatf(" is_version_b %0d/%0d", exp_r.is_version_b,
                                  got.is_version_b)};
      if (got.prog_id !== exp_r.prog_id)
        diffs = {diffs, $sformatf(" prog_id %h/%h", exp_r.prog_id, got.prog_id)};
      if (got.prog_type !== exp_r.prog_type)
        diffs = {diffs, $sformatf(" prog_type %0d/%0d", exp_r.prog_type, got.prog_type)};
      if (got.flag_bits !== exp_r.flag_bits)
        diffs = {diffs, $sformatf(" flag_bits %b/%b", exp_r.flag_bits, got.flag_bits)};
      if (got.af_first_khz !== exp_r.af_first_khz)
        diffs = {diffs, $sformatf(" af_first_khz %0d/%0d", exp_r.af_first_khz,
                                  got.af_first_khz)};
      if (got.af_second_khz !== exp_r.af_second_khz)
        diffs = {diffs, $sformatf(" af_second_khz %0d/%0d", exp_r.af_second_khz,
                                  got.af_second_khz)};
      if (got.text_ab !== exp_r.text_ab)
        diffs = {diffs, $sformatf(" text_ab %0d/%0d", exp_r.text_ab, got.text_ab)};
      if (got.read_char !== exp_r.read_char)
        diffs = {diffs, $sformatf(" read_char %h/%h", exp_r.read_char, got.read_char)};
      if (diffs != "") begin
        n_errors++;
        if (n_errors <= 10)
          $display("mismatch on result beat %0d (expected/actual):%s", n_checked, diffs);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;

  rds_result_checker rds_chk = new();
  idle_mode_t        src_mode = IDLE_FULL;
  idle_mode_t        snk_mode = IDLE_FULL;
  bit                hold_req = 1'b0;
  bit                stim_ab = 1'b0;

  rds_group_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap(idle_mode_t m);
    case (m)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 15);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
    endcase
  endfunction

  function automatic logic [15:0] blk_b(int gt, bit vb, bit tp, int pty, int low5);
    return {4'(gt), vb, tp, 5'(pty), 5'(low5)};
  endfunction

  function automatic rdsgd_pkg::item_t group_beat(logic [15:0] a, logic [15:0] b,
                                                  logic [15:0] c, logic [15:0] d);
    rdsgd_pkg::item_t it;
    it.cmd        = rdsgd_pkg::CMD_GROUP;
    it.read_index = 7'($urandom_range(0, 127));
    it.block_a    = a;
    it.block_b    = b;
    it.block_c    = c;
    it.block_d    = d;
    return it;
  endfunction

  function automatic rdsgd_pkg::item_t read_beat(int idx);
    rdsgd_pkg::item_t it;
    it.cmd        = rdsgd_pkg::CMD_READ;
    it.read_index = 7'(idx);
    it.block_a    = 16'($urandom);
    it.block_b    = 16'($urandom);
    it.block_c    = 16'($urandom);
    it.block_d    = 16'($urandom);
    return it;
  endfunction

  // Spreads AF codes over band switches, both frequency tables and the unused codes.
  function automatic logic [7:0] pick_af();
    case ($urandom_range(0, 8))
      0: return rdsgd_pkg::AF_LFMF_SET;
      1: return 8'($urandom_range(225, 249));
      2: return 8'($urandom_range(1, 15));
      3: return 8'($urandom_range(16, 135));
      4: return 8'($urandom_range(136, 204));
      5: return 8'($urandom_range(205, 224));
      6: return 8'($urandom_range(251, 255));
      7: return 8'd0;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed type 0 and type 2 groups that build up name and text,
  // with reads of the stores and some groups of arbitrary type.
  function automatic rdsgd_pkg::item_t random_beat();
    int sel;
    bit vb;
    sel = $urandom_range(0, 99);
    vb  = ($urandom_range(0, 3) == 0);
    if (sel < 30) begin
      return read_beat(($urandom_range(0, 9) < 8) ? $urandom_range(0, 71)
                                                   : $urandom_range(72, 127));
    end else if (sel < 55) begin
      return group_beat(16'($urandom),
                        blk_b(rdsgd_pkg::GT_BASIC, vb, $urandom_range(0, 1),
                              $urandom_range(0, 31), $urandom_range(0, 31)),
                        {pick_af(), pick_af()}, 16'($urandom));
    end else if (sel < 85) begin
      if ($urandom_range(0, 19) == 0) stim_ab = !stim_ab;
      return group_beat(16'($urandom),
                        blk_b(rdsgd_pkg::GT_TEXT, vb, $urandom_range(0, 1),
                              $urandom_range(0, 31), {stim_ab, 4'($urandom_range(0, 15))}),
                        16'($urandom), 16'($urandom));
    end
    return group_beat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  task automatic push(input rdsgd_pkg::item_t it);
    int gap;
    gap = draw_gap(src_mode);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.cmd;
    s_tdata  <= {1'b0, it.read_index, it.block_d, it.block_c, it.block_b, it.block_a};
    do @(posedge clk); while (!s_tready);
    rds_chk.note_beat(it);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (rds_chk.pending() > 0) @(posedge clk);
  endtask

  // Result side: random stalls per beat, and one long hold when requested.
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    m_tready <= 1'b1;
    forever begin
      if (hold_req) begin
        stall    = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        stall = draw_gap(snk_mode);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        m_tready <= 1'b1;
      end
      do @(posedge clk); while (!m_tvalid);
      rds_chk.check_beat(rdsgd_pkg::result_t'(m_tdata[75:0]));
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset contents and an out-of-range read.
    push(read_beat(0));
    push(read_beat(71));
    push(read_beat(127));
    // AF tables: LF/MF switch then both ends of LF and MF, back to VHF, and dead codes.
    push(group_beat(16'hFFFF, blk_b(rdsgd_pkg::GT_BASIC, 0, 1, 31, 5'b11100),
                    {8'd250, 8'd1}, 16'hFFFF));
    push(group_beat(16'h0000, blk_b(rdsgd_pkg::GT_BASIC, 0, 0, 0, 5'b00001),
                    {8'd15, 8'd16}, 16'h4142));
    push(group_beat(16'h1234, blk_b(rdsgd_pkg::GT_BASIC, 0, 1, 7, 5'b00110),
                    {8'd135, 8'd136}, 16'h4344));
    push(group_beat(16'h5678, blk_b(rdsgd_pkg::GT_BASIC, 0, 0, 9, 5'b00111),
                    {8'd225, 8'd204}, 16'h4546));
    push(group_beat(16'h9ABC, blk_b(rdsgd_pkg::GT_BASIC, 0, 1, 1, 5'b00000),
                    {8'd1, 8'd205}, 16'h0000));
    push(group_beat(16'hDEF0, blk_b(rdsgd_pkg::GT_BASIC, 0, 0, 2, 5'b00000),
                    {8'd0, 8'd255}, 16'h7F80));
    push(group_beat(16'h0F0F, blk_b(rdsgd_pkg::GT_BASIC, 0, 0, 3, 5'b00001),
                    {8'd250, 8'd100}, 16'h2E2E));
    // Version B carries no AF codes, so the band must survive this group.
    push(group_beat(16'hF0F0, blk_b(rdsgd_pkg::GT_BASIC, 1, 1, 5, 5'b10011),
                    {8'd225, 8'd1}, 16'h3132));
    push(group_beat(16'hAAAA, blk_b(rdsgd_pkg::GT_BASIC, 0, 0, 6, 5'b00010),
                    {8'd1, 8'd0}, 16'h3334));
    push(group_beat(16'h5555, blk_b(rdsgd_pkg::GT_BASIC, 0, 1, 8, 5'b00011),
                    {8'd224, 8'd251}, 16'h3536));
    // Radiotext: A/B change clears, last segments of both versions, then clear again.
    push(group_beat(16'h1111, blk_b(rdsgd_pkg::GT_TEXT, 0, 1, 31, 5'b11111),
                    16'h4142, 16'h4344));
    push(read_beat(68));
    push(read_beat(71));
    push(group_beat(16'h2222, blk_b(rdsgd_pkg::GT_TEXT, 1, 0, 4, 5'b11111),
                    16'hFFFF, 16'h4546));
    push(read_beat(70));
    push(group_beat(16'h3333, blk_b(rdsgd_pkg::GT_TEXT, 0, 0, 4, 5'b00000),
                    16'h6162, 16'h6364));
    push(read_beat(71));
    push(read_beat(8));
    // Other group types only update PI and PTY.
    push(group_beat(16'h8000, blk_b(15, 1, 1, 31, 31), 16'hFFFF, 16'hFFFF));
    push(group_beat(16'h0001, blk_b(1, 0, 0, 10, 7), 16'h0000, 16'h0000));
    push(read_beat(7));
    push(read_beat(72));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      src_mode = idle_mode_t'(p % 3);
      snk_mode = idle_mode_t'((p / 3) % 3);
      if (p == 2) begin
        // The result side holds off while beats keep coming, so the input backs up.
        hold_req = 1'b1;
        src_mode = IDLE_NONE;
      end
      for (int j = 0; j < PHASE_LEN; j++) push(random_beat());
      if (p == 5) drain();
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (rds_chk.n_errors == 0 && rds_chk.pending() == 0) begin
      $display("** rds_group_decoder_core: PASSED **");
    end else begin
      $display("** rds_group_decoder_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** rds_group_decoder_core: FAILED **");
    $finish;
  end

endmodule

[rds_group_decoder_core.f]
sv/rdsgd_pkg.sv
sv/rdsgd_text_store.sv
sv/rdsgd_group_proc.sv
sv/rds_group_decoder_core.sv
tb/sv/tb_rds_group_decoder_core.sv
